// ----- rtl/rekd_pkg.sv -----
package rekd_pkg;

    localparam logic [2:0] KEY_RIGHT = 3'd0;
    localparam logic [2:0] KEY_LEFT  = 3'd1;
    localparam logic [2:0] KEY_UP    = 3'd2;
    localparam logic [2:0] KEY_DOWN  = 3'd3;
    localparam logic [2:0] KEY_ENTER = 3'd4;

    localparam logic [1:0] REG_STEPS_PER_DETENT = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_MS      = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS_MS    = 2'd2;
    localparam logic [1:0] REG_RESULT_CAPACITY  = 2'd3;

    localparam logic [2:0]  STEPS_RESET      = 3'd4;
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd500;
    localparam logic [1:0]  CAPACITY_RESET   = 2'd2;

    // quadrature step per {previous ab, current ab}
    localparam logic signed [1:0] QUAD_DELTA [16] = '{
        2'sd0,  -2'sd1, 2'sd1,  2'sd0,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd0,  2'sd1,  -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic [2:0]  steps_per_detent;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [1:0]  result_capacity;
    } cfg_t;

    typedef struct packed {
        logic               primed;
        logic [1:0]         previous_ab;
        logic signed [3:0]  detent_accumulator;
        logic               adjust_mode;
        logic               raw_pressed_seen;
        logic               stable_pressed;
        logic [31:0]        level_change_time;
        logic               long_press_sent;
    } state_t;

    typedef struct packed {
        logic [1:0]       count;
        logic [1:0][2:0]  keys;
    } result_t;

endpackage

// ----- rtl/rekd_step.sv -----
module rekd_step (
    input  rekd_pkg::cfg_t    cfg,
    input  rekd_pkg::state_t  state,
    input  logic [1:0]        quad_ab,
    input  logic              button_down,
    input  logic [31:0]       time_ms,
    output rekd_pkg::state_t  state_next,
    output rekd_pkg::result_t result
);

    logic [1:0]         cap;
    logic [2:0]         steps;
    logic signed [4:0]  stp;
    logic signed [4:0]  sum;
    logic signed [4:0]  acc;
    logic [1:0]         cnt;
    logic signed [1:0]  delta;
    logic [31:0]        elapsed;
    logic [31:0]        held;
    logic [2:0]         up_key;
    logic [2:0]         dn_key;

    assign cap   = (cfg.result_capacity == 2'd3) ? 2'd2 : cfg.result_capacity;
    assign steps = (cfg.steps_per_detent == 3'd0) ? 3'd1 : cfg.steps_per_detent;
    assign stp   = signed'({2'b00, steps});
    assign delta = rekd_pkg::QUAD_DELTA[{state.previous_ab, quad_ab}];
    assign sum   = {state.detent_accumulator[3], state.detent_accumulator}
                 + {{3{delta[1]}}, delta};
    assign up_key = state.adjust_mode ? rekd_pkg::KEY_UP : rekd_pkg::KEY_RIGHT;
    assign dn_key = state.adjust_mode ? rekd_pkg::KEY_DOWN : rekd_pkg::KEY_LEFT;
    assign elapsed = time_ms - state.level_change_time;

    always_comb begin
        state_next = state;
        result     = '0;
        cnt        = 2'd0;
        acc        = 5'sd0;
        held       = '0;
        if (cap != 2'd0) begin
            if (!state.primed) begin
                state_next.primed             = 1'b1;
                state_next.previous_ab        = quad_ab;
                state_next.detent_accumulator = 4'sd0;
                state_next.raw_pressed_seen   = button_down;
                state_next.stable_pressed     = button_down;
                state_next.level_change_time  = time_ms;
                state_next.long_press_sent    = 1'b0;
            end else begin
                state_next.previous_ab = quad_ab;
                if (sum > 5'sd7) begin
                    acc = 5'sd7;
                end else if (sum < -5'sd8) begin
                    acc = -5'sd8;
                end else begin
                    acc = sum;
                end
                for (int i = 0; i < 2; i++) begin
                    if (acc >= stp && cnt < cap) begin
                        acc = acc - stp;
                        result.keys[cnt[0]] = up_key;
                        cnt = cnt + 2'd1;
                    end
                end
                for (int i = 0; i < 2; i++) begin
                    if (acc <= -stp && cnt < cap) begin
                        acc = acc + stp;
                        result.keys[cnt[0]] = dn_key;
                        cnt = cnt + 2'd1;
                    end
                end
                state_next.detent_accumulator = acc[3:0];

                if (button_down != state.raw_pressed_seen) begin
                    state_next.raw_pressed_seen  = button_down;
                    state_next.level_change_time = time_ms;
                end else if (elapsed >= {16'd0, cfg.debounce_ms}
                             && state.stable_pressed != state.raw_pressed_seen) begin
                    state_next.stable_pressed = state.raw_pressed_seen;
                    if (state.raw_pressed_seen) begin
                        state_next.long_press_sent = 1'b0;
                    end else if (!state.long_press_sent && cnt < cap) begin
                        state_next.adjust_mode = !state.adjust_mode;
                    end
                end

                held = time_ms - state_next.level_change_time;
                // enter fires once per held press
                if (state_next.stable_pressed && !state_next.long_press_sent
                    && held >= {16'd0, cfg.long_press_ms} && cnt < cap) begin
                    state_next.long_press_sent = 1'b1;
                    result.keys[cnt[0]] = rekd_pkg::KEY_ENTER;
                    cnt = cnt + 2'd1;
                end
            end
        end
        result.count = cnt;
    end

endmodule

// ----- rtl/rekd_outbuf.sv -----
module rekd_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  rekd_pkg::result_t  result,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,    // [2:0] key_code, [7:3] zero
    output logic               m_tlast     // last_of_run
);

    logic [1:0]       rem_reg, rem_next;
    logic             pos_reg, pos_next;
    logic [1:0][2:0]  keys_reg, keys_next;
    logic             take;

    assign m_tvalid = (rem_reg != 2'd0);
    assign take     = m_tvalid && m_tready;
    assign free     = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);
    assign m_tdata  = {5'd0, keys_reg[pos_reg]};
    assign m_tlast  = (rem_reg == 2'd1);

    always_comb begin
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        keys_next = keys_reg;
        if (load) begin
            rem_next  = result.count;
            pos_next  = 1'b0;
            keys_next = result.keys;
        end else if (take) begin
            rem_next = rem_reg - 2'd1;
            pos_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            pos_reg <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
        keys_reg <= keys_next;
    end

endmodule

// ----- rtl/rotary_encoder_key_decoder.sv -----
// channel   ports                     fields (low bit first)
// input     s_tvalid/s_tready/s_tdata quad_ab[1:0], button_down[2], time_ms[34:3]
// result    m_tvalid/m_tready/m_tdata key_code[2:0]; last_of_run on m_tlast
// config    cfg_wr_en/cfg_addr/cfg_wdata  index 0..3, data 16 bits
//
// first key shows when its sample moves from input register into result buffer
// a sample giving at most one key is taken every cycle while m_tready is high;
// two keys hold the result buffer until both go out; the input register waits
// sync active-low reset restores register defaults and clears control state
// a stall on m_tready backs up through the buffer to s_tready
module rotary_encoder_key_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // quad_ab, button_down, time_ms, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // key_code, zero pad
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    rekd_pkg::cfg_t     cfg_reg;
    rekd_pkg::state_t   state_reg;
    rekd_pkg::state_t   state_next;
    rekd_pkg::result_t  result;
    logic               in_valid_reg;
    logic [1:0]         in_ab_reg;
    logic               in_btn_reg;
    logic [31:0]        in_time_reg;
    logic               free;
    logic               adv;

    assign adv      = in_valid_reg && free;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steps_per_detent <= rekd_pkg::STEPS_RESET;
            cfg_reg.debounce_ms      <= rekd_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms    <= rekd_pkg::LONG_PRESS_RESET;
            cfg_reg.result_capacity  <= rekd_pkg::CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rekd_pkg::REG_STEPS_PER_DETENT: cfg_reg.steps_per_detent <= cfg_wdata[2:0];
                rekd_pkg::REG_DEBOUNCE_MS:      cfg_reg.debounce_ms      <= cfg_wdata;
                rekd_pkg::REG_LONG_PRESS_MS:    cfg_reg.long_press_ms    <= cfg_wdata;
                rekd_pkg::REG_RESULT_CAPACITY:  cfg_reg.result_capacity  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                state_reg <= state_next;
            end
        end
        if (s_tready && s_tvalid) begin
            in_ab_reg   <= s_tdata[1:0];
            in_btn_reg  <= s_tdata[2];
            in_time_reg <= s_tdata[34:3];
        end
    end

    rekd_step u_step (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .quad_ab     (in_ab_reg),
        .button_down (in_btn_reg),
        .time_ms     (in_time_reg),
        .state_next  (state_next),
        .result      (result)
    );

    rekd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (adv),
        .result   (result),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/rekd_checker.sv -----
module rekd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result item changed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4 && m_tdata[7:3] == 5'd0)
        else $error("bad key code");

    // second key of a run follows at once
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run broken");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output or ready wrong after reset");

    // keys are never valid straight out of reset
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result item without a sample");

endmodule

bind rotary_encoder_key_decoder rekd_checker u_rekd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/rotary_encoder_key_decoder_tb.sv -----
module rotary_encoder_key_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int HOLD_CYCLES = 400;

    // position of each ab pair along the clockwise cycle 00 -> 10 -> 11 -> 01
    localparam int GRAY_POS [4] = '{0, 3, 1, 2};
    localparam logic [1:0] POS_AB [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ONE} exp_mode_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  addr;
        logic [15:0] data;
        logic [1:0]  ab;
        logic        btn;
        logic [31:0] tm;
        exp_mode_e   mode;
        logic [2:0]  key;
    } dir_row_t;

    typedef struct packed {
        logic [2:0] code;
        logic       last;
    } key_event_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    rotary_encoder_key_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // decoder copy: registers
    logic [2:0]  steps_r = rekd_pkg::STEPS_RESET;
    logic [15:0] deb_r   = rekd_pkg::DEBOUNCE_RESET;
    logic [15:0] long_r  = rekd_pkg::LONG_PRESS_RESET;
    logic [1:0]  cap_r   = rekd_pkg::CAPACITY_RESET;

    // decoder copy: state
    logic        primed_q   = 1'b0;
    logic [1:0]  prev_ab_q  = 2'd0;
    int          acc_q      = 0;
    logic        adjust_q   = 1'b0;
    logic        raw_q      = 1'b0;
    logic        stable_q   = 1'b0;
    logic [31:0] change_t_q = '0;
    logic        lp_sent_q  = 1'b0;

    key_event_t pending_keys [$];
    key_event_t head_key;
    int fail_count = 0;
    int cycle_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // stimulus generator state
    logic [1:0]  gen_ab;
    int          gen_pos;
    logic        gen_btn;
    logic [31:0] gen_time;
    int          rot_dir;
    int          run_left;

    dir_row_t dir_rows [28] = '{
        '{ROW_CFG, rekd_pkg::REG_RESULT_CAPACITY, 16'd0, 2'd0, 1'b0, 32'd0,
          EXP_NONE, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b1, 32'd5,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_CFG, rekd_pkg::REG_RESULT_CAPACITY, 16'd3, 2'd0, 1'b0, 32'd0,
          EXP_NONE, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd0, 1'b0, 32'd0,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd2, 1'b0, 32'd1,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd2,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd1, 1'b0, 32'd3,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd0, 1'b0, 32'd4,   EXP_ONE,     rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd1, 1'b0, 32'd5,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd6,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd2, 1'b0, 32'd7,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd0, 1'b0, 32'd8,   EXP_ONE,     rekd_pkg::KEY_LEFT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd9,   EXP_NONE,    rekd_pkg::KEY_RIGHT},
        '{ROW_CFG, rekd_pkg::REG_STEPS_PER_DETENT, 16'd0, 2'd0, 1'b0, 32'd0,
          EXP_NONE, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd1, 1'b0, 32'd10,  EXP_ONE,     rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd11,  EXP_ONE,     rekd_pkg::KEY_LEFT},
        '{ROW_CFG, rekd_pkg::REG_STEPS_PER_DETENT, 16'd4, 2'd0, 1'b0, 32'd0,
          EXP_NONE, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b1, 32'd100, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b1, 32'd130, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd140, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd170, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd1, 1'b0, 32'd171, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd0, 1'b0, 32'd172, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd2, 1'b0, 32'd173, EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b0, 32'd174, EXP_ONE,     rekd_pkg::KEY_UP},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b1, 32'hffff_ffff,
          EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd3, 1'b1, 32'h1e,  EXP_PREDICT, rekd_pkg::KEY_RIGHT},
        '{ROW_SAMPLE, 2'd0, 16'd0, 2'd1, 1'b1, 32'h200, EXP_ONE,     rekd_pkg::KEY_ENTER}
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d keys still due", cycle_count,
                     pending_keys.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // keys the decoder should produce for one sample; updates the decoder copy
    task automatic decode_sample(input logic [1:0] ab, input logic btn, input logic [31:0] now,
                                 output int n, output logic [2:0] codes [2]);
        int cap;
        int steps;
        int diff;
        int acc;
        logic [31:0] since;
        n = 0;
        codes[0] = rekd_pkg::KEY_RIGHT;
        codes[1] = rekd_pkg::KEY_RIGHT;
        cap = (cap_r > 2) ? 2 : int'(cap_r);
        steps = (steps_r == 0) ? 1 : int'(steps_r);
        if (cap == 0)
            return;
        if (!primed_q) begin
            prev_ab_q = ab;
            acc_q = 0;
            raw_q = btn;
            stable_q = btn;
            change_t_q = now;
            lp_sent_q = 1'b0;
            primed_q = 1'b1;
            return;
        end
        diff = (GRAY_POS[ab] - GRAY_POS[prev_ab_q] + 4) % 4;
        acc = acc_q + ((diff == 1) ? 1 : (diff == 3) ? -1 : 0);
        prev_ab_q = ab;
        if (acc > 7)
            acc = 7;
        if (acc < -8)
            acc = -8;
        while (acc >= steps && n < cap) begin
            acc -= steps;
            codes[n] = adjust_q ? rekd_pkg::KEY_UP : rekd_pkg::KEY_RIGHT;
            n++;
        end
        while (acc <= -steps && n < cap) begin
            acc += steps;
            codes[n] = adjust_q ? rekd_pkg::KEY_DOWN : rekd_pkg::KEY_LEFT;
            n++;
        end
        acc_q = acc;

        since = now - change_t_q;
        if (btn != raw_q) begin
            raw_q = btn;
            change_t_q = now;
        end else if (since >= {16'd0, deb_r} && stable_q != raw_q) begin
            stable_q = raw_q;
            if (stable_q)
                lp_sent_q = 1'b0;
            else if (!lp_sent_q && n < cap)
                adjust_q = !adjust_q;
        end
        since = now - change_t_q;
        if (stable_q && !lp_sent_q && since >= {16'd0, long_r} && n < cap) begin
            lp_sent_q = 1'b1;
            codes[n] = rekd_pkg::KEY_ENTER;
            n++;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic offer_sample(input logic [1:0] ab, input logic btn, input logic [31:0] now,
                                input exp_mode_e mode, input logic [2:0] key);
        int n;
        logic [2:0] codes [2];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, now, btn, ab};
        do
            @(posedge aclk);
        while (!s_tready);
        decode_sample(ab, btn, now, n, codes);
        if (mode == EXP_ONE) begin
            pending_keys.push_back('{code: key, last: 1'b1});
        end else if (mode == EXP_PREDICT) begin
            for (int i = 0; i < n; i++)
                pending_keys.push_back('{code: codes[i], last: (i == n - 1)});
        end
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_keys.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            rekd_pkg::REG_STEPS_PER_DETENT: steps_r = data[2:0];
            rekd_pkg::REG_DEBOUNCE_MS:      deb_r = data;
            rekd_pkg::REG_LONG_PRESS_MS:    long_r = data;
            rekd_pkg::REG_RESULT_CAPACITY:  cap_r = data[1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic random_samples(input int count);
        int r;
        logic btn;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 70)
                gen_time += $urandom_range(15);
            else if (r < 96)
                gen_time += $urandom_range(400, 16);
            else
                gen_time += $urandom;

            if (run_left == 0) begin
                rot_dir = int'($urandom_range(2)) - 1;
                run_left = $urandom_range(12, 1);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 6) begin
                // noise, illegal jumps included
                gen_ab = 2'($urandom_range(3));
                gen_pos = GRAY_POS[gen_ab];
            end else if (r < 85 && rot_dir != 0) begin
                gen_pos = (gen_pos + rot_dir + 4) % 4;
                gen_ab = POS_AB[gen_pos];
            end

            if ($urandom_range(99) < 6)
                gen_btn = !gen_btn;
            btn = gen_btn ^ ($urandom_range(99) < 4);
            offer_sample(gen_ab, btn, gen_time, EXP_PREDICT, rekd_pkg::KEY_RIGHT);
        end
    endtask

    // receiver: random stalls plus a single long hold-off
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_keys.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected key %0d last %0b", m_tdata[2:0], m_tlast);
                fail_count++;
            end else begin
                head_key = pending_keys.pop_front();
                if (m_tdata[2:0] !== head_key.code || m_tlast !== head_key.last) begin
                    if (fail_count < 10)
                        $display("key mismatch: expected %0d last %0b, got %0d last %0b",
                                 head_key.code, head_key.last, m_tdata[2:0], m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int steps;
        int deb;
        int lng;
        int cap;
        int count;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].addr, dir_rows[i].data);
            end else begin
                offer_sample(dir_rows[i].ab, dir_rows[i].btn, dir_rows[i].tm,
                             dir_rows[i].mode, dir_rows[i].key);
            end
        end

        gen_ab = dir_rows[27].ab;
        gen_pos = GRAY_POS[gen_ab];
        gen_btn = 1'b1;
        gen_time = $urandom;
        rot_dir = 0;
        run_left = 0;

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    steps = 4; deb = 30; lng = 500; cap = 2;
                    send_idle_pct = 0; recv_stall_pct = 0; count = 300;
                end
                1: begin
                    steps = 1; deb = 0; lng = 0; cap = 2;
                    send_idle_pct = 72; recv_stall_pct = 0; count = 250;
                end
                2: begin
                    steps = 7; deb = 65535; lng = 65535; cap = 1;
                    send_idle_pct = 0; recv_stall_pct = 72; count = 250;
                end
                3: begin
                    steps = 2; deb = $urandom_range(40, 5); lng = $urandom_range(600, 50);
                    cap = 3;
                    send_idle_pct = 22; recv_stall_pct = 22; count = 300;
                end
                4: begin
                    // everything ignored
                    steps = 4; deb = 30; lng = 500; cap = 0;
                    send_idle_pct = 0; recv_stall_pct = 0; count = 20;
                end
                5: begin
                    steps = $urandom_range(7); deb = $urandom_range(60);
                    lng = $urandom_range(800); cap = 2;
                    send_idle_pct = 0; recv_stall_pct = 72; count = 300;
                end
                6: begin
                    steps = 3; deb = 10; lng = 100; cap = 1;
                    send_idle_pct = 72; recv_stall_pct = 0; count = 250;
                end
                default: begin
                    steps = $urandom_range(7); deb = $urandom_range(100);
                    lng = $urandom_range(1000); cap = $urandom_range(3, 1);
                    send_idle_pct = 22; recv_stall_pct = 22; count = 300;
                end
            endcase
            settle();
            write_reg(rekd_pkg::REG_STEPS_PER_DETENT, 16'(steps));
            write_reg(rekd_pkg::REG_DEBOUNCE_MS, 16'(deb));
            write_reg(rekd_pkg::REG_LONG_PRESS_MS, 16'(lng));
            write_reg(rekd_pkg::REG_RESULT_CAPACITY, 16'(cap));
            if (p == 3)
                hold_seq++;
            random_samples(count);
        end

        settle();
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rekd_pkg.sv
rtl/rekd_step.sv
rtl/rekd_outbuf.sv
rtl/rotary_encoder_key_decoder.sv
rtl/rekd_checker.sv
tb/sv/rotary_encoder_key_decoder_tb.sv
